@@ src/base64url_strict_decoder_macros.svh @@
// Assertion macros used by the back part of the base64url decoder RTL.
// Depends on nothing; files that assert include it by name.
`ifndef BASE64URL_STRICT_DECODER_MACROS_SVH
`define BASE64URL_STRICT_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B64D_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define B64D_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/b64d_pkg.sv @@
// Types, constants and the character map of the base64url decoder.
// Used by every module of the block; depends on nothing.
package b64d_pkg;

    localparam int LIMIT_BITS = 16;
    localparam int CNT_W      = LIMIT_BITS + 1;
    localparam int CFG_W      = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_ZERO    = 3'd1,
        STAT_BAD_LEN = 3'd2,
        STAT_OVER    = 3'd3,
        STAT_INVALID = 3'd4,
        STAT_PAD     = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_res;
        logic [2:0] status;
    } out_item_t;

    // One classified character as it waits between the front and back parts.
    typedef struct packed {
        logic [5:0] sextet;
        logic       bad;
        logic       last;
    } sx_entry_t;

    // Returns {valid, sextet}; an invalid byte maps to sextet zero.
    function automatic logic [6:0] map_char(input logic [7:0] ch);
        logic [5:0] sx;
        logic       ok;
        sx = '0;
        ok = 1'b1;
        if (ch inside {[8'h41:8'h5A]}) begin
            sx = 6'(ch - 8'h41);
        end else if (ch inside {[8'h61:8'h7A]}) begin
            sx = 6'(ch - 8'h61 + 8'd26);
        end else if (ch inside {[8'h30:8'h39]}) begin
            sx = 6'(ch - 8'h30 + 8'd52);
        end else if (ch == 8'h2D) begin
            sx = 6'd62;
        end else if (ch == 8'h5F) begin
            sx = 6'd63;
        end else begin
            ok = 1'b0;
        end
        return {ok, sx};
    endfunction

endpackage

@@ src/b64d_front.sv @@
// Front part of the decoder: accepts characters and classifies them.
// Depends on b64d_pkg; feeds b64d_fifo.
module b64d_front import b64d_pkg::*; (
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      q_wr_valid,
    input  logic      q_wr_ready,
    output sx_entry_t q_wr_data
);

    logic [6:0] mapped;

    assign mapped             = map_char(s_data.character);
    assign s_ready            = q_wr_ready;
    assign q_wr_valid         = s_valid;
    assign q_wr_data.sextet   = mapped[5:0];
    assign q_wr_data.bad      = ~mapped[6];
    assign q_wr_data.last     = s_data.last;

endmodule

@@ src/b64d_fifo.sv @@
// Short queue of classified characters between the front and back parts.
// Depends on b64d_pkg.
module b64d_fifo import b64d_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  sx_entry_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output sx_entry_t rd_data
);

    sx_entry_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 push, pop;

    assign wr_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ src/b64d_back.sv @@
// Back part of the decoder: assembles bytes, tracks the string and sets the status.
// Depends on b64d_pkg and the assertion macros header.
`include "base64url_strict_decoder_macros.svh"

module b64d_back import b64d_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             q_rd_valid,
    output logic             q_rd_ready,
    input  sx_entry_t        q_rd_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    logic [LIMIT_BITS-1:0] limit_reg, limit_next;
    logic [1:0]            pos_reg, pos_next;
    logic [5:0]            held_reg, held_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  err_reg, err_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    logic                  pop;
    logic                  has_byte;
    logic                  produce;
    logic [7:0]            byte_val;
    logic [CNT_W-1:0]      cnt_upd;
    logic                  err_upd;
    status_t               stat;

    assign q_rd_ready = !m_valid_reg || m_ready;
    assign pop        = q_rd_valid && q_rd_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_comb begin
        byte_val = '0;
        case (pos_reg)
            2'd1:    byte_val = {held_reg, q_rd_data.sextet[5:4]};
            2'd2:    byte_val = {held_reg[3:0], q_rd_data.sextet[5:2]};
            2'd3:    byte_val = {held_reg[1:0], q_rd_data.sextet};
            default: byte_val = '0;
        endcase
        has_byte = (pos_reg != 2'd0);
        produce  = has_byte || q_rd_data.last;
        // The count stops once its top bit is set, which lies above any limit.
        cnt_upd  = cnt_reg + CNT_W'(has_byte && !cnt_reg[CNT_W-1]);
        err_upd  = err_reg || q_rd_data.bad;

        if (limit_reg == '0) begin
            stat = STAT_ZERO;
        end else if (pos_reg == 2'd0) begin
            stat = STAT_BAD_LEN;
        end else if (cnt_upd > {1'b0, limit_reg}) begin
            stat = STAT_OVER;
        end else if (err_upd) begin
            stat = STAT_INVALID;
        end else if ((pos_reg == 2'd1 && q_rd_data.sextet[3:0] != 4'd0) ||
                     (pos_reg == 2'd2 && q_rd_data.sextet[1:0] != 2'd0)) begin
            stat = STAT_PAD;
        end else begin
            stat = STAT_OK;
        end
    end

    always_comb begin
        limit_next   = cfg_we ? LIMIT_BITS'(cfg_wdata) : limit_reg;
        pos_next     = pos_reg;
        held_next    = held_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (pop) begin
            if (q_rd_data.last) begin
                pos_next  = '0;
                held_next = '0;
                cnt_next  = '0;
                err_next  = 1'b0;
            end else begin
                pos_next  = pos_reg + 2'd1;
                held_next = q_rd_data.sextet;
                cnt_next  = cnt_upd;
                err_next  = err_upd;
            end
            if (produce) begin
                m_valid_next           = 1'b1;
                m_data_next.data_byte  = byte_val;
                m_data_next.byte_valid = has_byte;
                m_data_next.last_res   = q_rd_data.last;
                m_data_next.status     = q_rd_data.last ? stat : STAT_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= LIMIT_BITS'(4096);
            pos_reg     <= '0;
            held_reg    <= '0;
            cnt_reg     <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            limit_reg   <= limit_next;
            pos_reg     <= pos_next;
            held_reg    <= held_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    `B64D_ASSERT_NEXT(a_last_clears_state, aclk, aresetn, pop && q_rd_data.last, pos_reg == 2'd0 && cnt_reg == '0 && !err_reg, "string state not cleared after final character")
    `B64D_ASSERT_NOW(a_status_only_on_last, aclk, aresetn, m_valid_reg && !m_data_reg.last_res, m_data_reg.status == STAT_OK, "status set on a result that is not final")
    `B64D_ASSERT_NOW(a_no_byte_is_zero, aclk, aresetn, m_valid_reg && !m_data_reg.byte_valid, m_data_reg.data_byte == 8'd0 && m_data_reg.last_res, "result without a byte is not a clean final result")
    `B64D_ASSERT_NOW(a_count_saturates, aclk, aresetn, cnt_reg[CNT_W-1], cnt_reg[CNT_W-2:0] == '0, "byte count passed its saturation value")

endmodule

@@ src/base64url_strict_decoder.sv @@
// Top level of the strict unpadded base64url decoder.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
//
//   Port group   Direction   Handshake          Carries
//   s_*          in          s_valid/s_ready    one character and its last flag
//   m_*          out         m_valid/m_ready    byte, byte flag, last flag, status
//   cfg_*        in          cfg_we             output_limit
//
// One character is taken per cycle while the queue has room; it is written into the queue,
// and the back part pops it and registers any result for it in the output register.
// Rate is set by the byte assembly in the back part and the output register.
// The four-entry queue lets the input keep flowing while m_ready is low, until it fills.
// Synchronous active-low reset clears the queue, string state and output valid,
// and sets output_limit to 4096.
module base64url_strict_decoder import b64d_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    logic      wr_valid, wr_ready;
    sx_entry_t wr_data;
    logic      rd_valid, rd_ready;
    sx_entry_t rd_data;

    b64d_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_wr_valid (wr_valid),
        .q_wr_ready (wr_ready),
        .q_wr_data  (wr_data)
    );

    b64d_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data)
    );

    b64d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_rd_valid (rd_valid),
        .q_rd_ready (rd_ready),
        .q_rd_data  (rd_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for base64url_strict_decoder: a directed table, then random strings.
// Depends on b64d_pkg for the request and result types and the status codes.
module tb_top;
    import b64d_pkg::*;

    localparam int WATCHDOG    = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int TAB_ROWS    = 30;
    localparam int PHASE_ITEMS = 165;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic       is_cfg;
        logic [15:0] limit;
        in_item_t   item;
        logic       known;
        out_item_t  result;
    } step_row_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;

    // Decoder state as the predictor sees it.
    logic [1:0]  grp_pos;
    logic [5:0]  held_sx;
    logic [16:0] byte_cnt;
    logic        str_bad;
    logic [15:0] out_limit;

    out_item_t decoded_q[$];
    out_item_t head;
    step_row_t dir_tab [TAB_ROWS];

    int  n_err;
    int  n_items;
    int  n_checked;
    int  n_strings;
    int  stat_seen [8];
    int  idle_cyc;
    bit  quiet;
    bit  hold_req;
    bit  held_off;
    bit  paused;

    base64url_strict_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic bit sextet_of(input logic [7:0] c, output logic [5:0] sx);
        sextet_of = 1'b1;
        if (c >= "A" && c <= "Z") sx = 6'(c - "A");
        else if (c >= "a" && c <= "z") sx = 6'(c - "a" + 26);
        else if (c >= "0" && c <= "9") sx = 6'(c - "0" + 52);
        else if (c == "-") sx = 6'd62;
        else if (c == "_") sx = 6'd63;
        else begin
            sx = 6'd0;
            sextet_of = 1'b0;
        end
    endfunction

    function automatic logic [7:0] char_of(input logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? 8'("-") : 8'("_");
    endfunction

    // Advances the string state by one character; returns 1 when a result is due.
    function automatic bit decode_step(input in_item_t it, output out_item_t res);
        logic [5:0] sx;
        logic [7:0] b;
        logic [1:0] pos;
        logic       has_b;
        status_t    st;
        if (!sextet_of(it.character, sx)) str_bad = 1'b1;
        pos   = grp_pos;
        has_b = (pos != 2'd0);
        case (pos)
            2'd1: b = {held_sx, sx[5:4]};
            2'd2: b = {held_sx[3:0], sx[5:2]};
            2'd3: b = {held_sx[1:0], sx};
            default: b = 8'h00;
        endcase
        if (has_b && byte_cnt < 17'h10000) byte_cnt = byte_cnt + 1'b1;
        held_sx = sx;
        grp_pos = pos + 2'd1;
        res = '0;
        if (!has_b && !it.last) return 1'b0;
        st = STAT_OK;
        if (it.last) begin
            if (out_limit == 16'd0) st = STAT_ZERO;
            else if (pos == 2'd0) st = STAT_BAD_LEN;
            else if (byte_cnt > {1'b0, out_limit}) st = STAT_OVER;
            else if (str_bad) st = STAT_INVALID;
            else if ((pos == 2'd1 && sx[3:0] != 4'd0) || (pos == 2'd2 && sx[1:0] != 2'd0))
                st = STAT_PAD;
            grp_pos  = 2'd0;
            held_sx  = 6'd0;
            byte_cnt = '0;
            str_bad  = 1'b0;
        end
        res.data_byte  = b;
        res.byte_valid = has_b;
        res.last_res   = it.last;
        res.status     = st;
        return 1'b1;
    endfunction

    function automatic step_row_t row_char(input logic [7:0] c, input logic l);
        row_char = '0;
        row_char.item.character = c;
        row_char.item.last      = l;
    endfunction

    function automatic step_row_t row_known(input logic [7:0] c, input logic l,
                                            input logic [7:0] b, input logic bv,
                                            input status_t st);
        row_known = row_char(c, l);
        row_known.known             = 1'b1;
        row_known.result.data_byte  = b;
        row_known.result.byte_valid = bv;
        row_known.result.last_res   = l;
        row_known.result.status     = st;
    endfunction

    function automatic step_row_t row_limit(input logic [15:0] v);
        row_limit = '0;
        row_limit.is_cfg = 1'b1;
        row_limit.limit  = v;
    endfunction

    task automatic flag(input string what, input int got, input int want);
        if (n_err < MAX_PRINTS)
            $display("ERROR at %0t: %s got %0h, expected %0h", $time, what, got, want);
        n_err++;
    endtask

    // Offers one request and, once it is taken, queues what the decoder should return.
    task automatic offer(input in_item_t it, input bit known, input out_item_t given);
        out_item_t res;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        if (decode_step(it, res)) decoded_q.insert(decoded_q.size(), known ? given : res);
        n_items++;
        if (it.last) n_strings++;
    endtask

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        out_limit = v;
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed strings with a random body; some lengths leave a character
    // over, a few carry a stray byte, and a few are pure noise.
    task automatic random_string();
        int         n;
        bit         junk;
        logic [5:0] v;
        in_item_t   it;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 13);
        else if ($urandom_range(0, 19) == 0) n = 4 * $urandom_range(3, 10) + $urandom_range(2, 4);
        else n = 4 * $urandom_range(0, 2) + $urandom_range(2, 4);
        junk = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < n; i++) begin
            it.last = (i == n - 1);
            if (junk) begin
                it.character = 8'($urandom_range(0, 255));
            end else begin
                v = 6'($urandom_range(0, 63));
                if (it.last && $urandom_range(0, 3) != 0) begin
                    if (i % 4 == 1) v[3:0] = 4'd0;
                    else if (i % 4 == 2) v[1:0] = 2'd0;
                end
                it.character = char_of(v);
                if ($urandom_range(0, 49) == 0) it.character = 8'($urandom_range(0, 255));
            end
            idle_gap();
            offer(it, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, one long hold-off on request, none once quiet.
    initial begin
        m_ready  = 1'b0;
        hold_req = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                flag("result with nothing pending", int'(m_data), 0);
            end else begin
                head = decoded_q.pop_front();
                if (m_data.data_byte !== head.data_byte)
                    flag("data_byte", m_data.data_byte, head.data_byte);
                if (m_data.byte_valid !== head.byte_valid)
                    flag("byte_valid", m_data.byte_valid, head.byte_valid);
                if (m_data.last_res !== head.last_res)
                    flag("last_res", m_data.last_res, head.last_res);
                if (m_data.status !== head.status)
                    flag("status", m_data.status, head.status);
                n_checked++;
                if (head.last_res) stat_seen[head.status]++;
            end
        end
    end

    initial begin
        idle_cyc = 0;
        while (idle_cyc < WATCHDOG) begin
            @(negedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cyc = 0;
            else idle_cyc++;
        end
        $display("watchdog: no request moved for %0d cycles", WATCHDOG);
        $display("base64url_strict_decoder: mismatch");
        $finish;
    end

    initial begin
        logic [15:0] phase_limit [5];
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        quiet     = 1'b0;
        held_off  = 1'b0;
        paused    = 1'b0;
        n_err     = 0;
        n_items   = 0;
        n_checked = 0;
        n_strings = 0;
        foreach (stat_seen[k]) stat_seen[k] = 0;
        grp_pos   = 2'd0;
        held_sx   = 6'd0;
        byte_cnt  = '0;
        str_bad   = 1'b0;
        out_limit = 16'd4096;

        dir_tab = '{
            row_char("A", 1'b0),
            row_known("A", 1'b1, 8'h00, 1'b1, STAT_OK),
            row_known("A", 1'b1, 8'h00, 1'b0, STAT_BAD_LEN),
            row_char("_", 1'b0),
            row_known("_", 1'b1, 8'hFF, 1'b1, STAT_PAD),
            row_char("_", 1'b0),
            row_known("w", 1'b1, 8'hFF, 1'b1, STAT_OK),
            row_char("A", 1'b0),
            row_known("*", 1'b1, 8'h00, 1'b1, STAT_INVALID),
            row_char("-", 1'b0),
            row_char("z", 1'b0),
            row_char("0", 1'b0),
            row_char("9", 1'b0),
            row_char("Z", 1'b0),
            row_char("a", 1'b0),
            row_char(8'hFF, 1'b0),
            row_char(8'h00, 1'b1),
            row_char("A", 1'b0),
            row_char("A", 1'b0),
            row_char("C", 1'b1),
            row_limit(16'd0),
            row_known("A", 1'b1, 8'h00, 1'b0, STAT_ZERO),
            row_char("A", 1'b0),
            row_known("A", 1'b1, 8'h00, 1'b1, STAT_ZERO),
            row_limit(16'd1),
            row_char("A", 1'b0),
            row_char("A", 1'b0),
            row_known("A", 1'b1, 8'h00, 1'b1, STAT_OVER),
            row_char("A", 1'b0),
            row_known("A", 1'b1, 8'h00, 1'b1, STAT_OK)
        };
        phase_limit = '{16'd2, 16'd0, 16'd9, 16'($urandom_range(1, 24)), 16'hFFFF};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_cfg) begin
                drain();
                write_limit(dir_tab[r].limit);
            end else begin
                idle_gap();
                offer(dir_tab[r].item, dir_tab[r].known, dir_tab[r].result);
            end
        end

        for (int p = 0; p < 5; p++) begin
            int start;
            drain();
            write_limit(phase_limit[p]);
            quiet = (p == 4);
            start = n_items;
            while (n_items - start < PHASE_ITEMS) begin
                // The block fills while results are held back, then the sender waits it out.
                if (p == 1 && !held_off && n_items - start >= 50) begin
                    hold_req = 1'b1;
                    held_off = 1'b1;
                end
                if (p == 3 && !paused && n_items - start >= 80) begin
                    drain();
                    paused = 1'b1;
                end
                random_string();
            end
        end

        drain();
        $display("ran %0d characters in %0d strings, %0d results checked", n_items, n_strings,
                 n_checked);
        $display("endings: ok %0d zero %0d length %0d over %0d invalid %0d pad %0d",
                 stat_seen[STAT_OK], stat_seen[STAT_ZERO], stat_seen[STAT_BAD_LEN],
                 stat_seen[STAT_OVER], stat_seen[STAT_INVALID], stat_seen[STAT_PAD]);
        if (n_err == 0) begin
            $display("base64url_strict_decoder: match");
        end else begin
            $display("base64url_strict_decoder: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_fifo.sv
src/b64d_back.sv
src/base64url_strict_decoder.sv
verif/tb_top.sv
